// ----- src/ntc_table_interpolate_temperature_assert.svh -----
// Assertion macros shared by the checker.
`ifndef NTC_TABLE_INTERPOLATE_TEMPERATURE_ASSERT_SVH
`define NTC_TABLE_INTERPOLATE_TEMPERATURE_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define NTC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is high.
`define NTC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also checks across reset.
`define NTC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/ntc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ntc_pkg;

   localparam int TABLE_DEPTH    = 256;
   localparam int TEMP_FRAC_BITS = 8;

   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = 9;
   localparam int VAL_W   = 24;
   localparam int BASE_W  = 8;
   localparam int TEMP_W  = 18;
   localparam int POS_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam int WHOLE_W = ((BASE_W > ADDR_W) ? BASE_W : ADDR_W) + 2;
   localparam int SUM_W   = WHOLE_W + TEMP_FRAC_BITS;
   localparam int EXT_W   = SUM_W + TEMP_W;
   localparam int DIV_CNT_W = $clog2(TEMP_FRAC_BITS + 1);

   localparam int TEMP_MAX = 2 ** (TEMP_W - 1) - 1;
   localparam int TEMP_MIN = -(2 ** (TEMP_W - 1));

   localparam logic [CNT_W-1:0]  ENTRIES_RESET = CNT_W'(141);
   localparam logic [BASE_W-1:0] BASE_RESET    = BASE_W'(-20);

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_ENTRIES    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_TEMPERATURE = CSR_IDX_W'(1);

   localparam logic ACTION_WRITE   = 1'b0;
   localparam logic ACTION_CONVERT = 1'b1;

endpackage

`default_nettype wire

// ----- src/ntc_table_interpolate_temperature.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Thermistor resistance to temperature. A write item (action 0) stores one
// table entry and gives no result. A convert item (action 1) gives one
// result: the table is a memory with one registered read port, read one entry
// per cycle, so the block reads entries 0 and n-1 for the range test, then, if
// the resistance is in range, binary searches, each step a read state and a
// compare state, then runs a restoring divider that makes one fraction bit per
// cycle. With fewer than two entries it skips all of this. req_stall is high
// from the transfer of a convert item until its result is loaded into the
// output register. Results wait in an output register, so the next item can be
// taken while a result is still unread; a convert holds in S_DONE until that
// register is free. Table entries have no reset value; only convert after the
// entries in use were written.
module ntc_table_interpolate_temperature import ntc_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_data,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_action,
   input  wire logic [ADDR_W-1:0]        req_entry_index,
   input  wire logic [VAL_W-1:0]         req_entry_value,
   input  wire logic [VAL_W-1:0]         req_resistance,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [TEMP_W-1:0]      rsp_temperature,
   output logic                          rsp_in_range,
   output logic [POS_W-1:0]              rsp_table_position
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_FIRST,
      S_RD_LAST,
      S_CHK_RANGE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_DIV_SETUP,
      S_DIV,
      S_DONE
   } state_type;

   state_type state_ff;

   logic [VAL_W-1:0] mem [TABLE_DEPTH];
   logic [VAL_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;

   logic [CNT_W-1:0]  entries_ff;
   logic [BASE_W-1:0] base_ff;

   logic [VAL_W-1:0]  res_ff;
   logic [ADDR_W-1:0] last_ff;
   logic [ADDR_W-1:0] lo_ff;
   logic [ADDR_W-1:0] hi_ff;
   logic [ADDR_W-1:0] mid_ff;
   logic [VAL_W-1:0]  lo_val_ff;
   logic [VAL_W-1:0]  hi_val_ff;
   logic              in_range_ff;
   logic [VAL_W-1:0]  rem_ff;
   logic [VAL_W-1:0]  den_ff;
   logic [TEMP_FRAC_BITS-1:0] quo_ff;
   logic [DIV_CNT_W-1:0]      div_cnt_ff;

   logic                      rsp_valid_ff;
   logic signed [TEMP_W-1:0]  rsp_temperature_ff;
   logic                      rsp_in_range_ff;
   logic [POS_W-1:0]          rsp_table_position_ff;

   logic              req_xfer;
   logic              rsp_slot_free;
   logic [CNT_W-1:0]  n_eff;
   logic [ADDR_W:0]   mid_sum;
   logic [ADDR_W-1:0] mid_in;
   logic [ADDR_W-1:0] span;
   logic [VAL_W:0]    rem_shift;
   logic              quo_bit;
   logic [VAL_W-1:0]  rem_in;
   logic signed [WHOLE_W-1:0] whole;
   logic signed [SUM_W-1:0]   temp_sum;
   logic signed [EXT_W-1:0]   temp_ext;
   logic signed [TEMP_W-1:0]  temp_sat;

   assign req_stall     = (state_ff != S_IDLE);
   assign req_xfer      = req_valid && !req_stall;
   assign rsp_slot_free = !rsp_valid_ff || !rsp_stall;

   assign n_eff   = (entries_ff > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entries_ff;
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_in  = mid_sum[ADDR_W:1];
   assign span    = hi_ff - lo_ff;

   // one restoring divide step per cycle
   assign rem_shift = {rem_ff, 1'b0};
   assign quo_bit   = (rem_shift >= {1'b0, den_ff});
   always_comb begin
      if (quo_bit) begin
         rem_in = VAL_W'(rem_shift - {1'b0, den_ff});
      end else begin
         rem_in = rem_shift[VAL_W-1:0];
      end
   end

   // whole degrees with the fraction appended, then clamp to the output range
   assign whole    = WHOLE_W'($signed(base_ff)) + WHOLE_W'({1'b0, lo_ff});
   assign temp_sum = {whole, quo_ff};
   assign temp_ext = EXT_W'(temp_sum);
   always_comb begin
      priority if (temp_ext > $signed(EXT_W'(TEMP_MAX))) begin
         temp_sat = TEMP_W'(TEMP_MAX);
      end else if (temp_ext < $signed(EXT_W'(TEMP_MIN))) begin
         temp_sat = TEMP_W'(TEMP_MIN);
      end else begin
         temp_sat = temp_ext[TEMP_W-1:0];
      end
   end

   always_comb begin
      unique case (state_ff)
         S_RD_FIRST: rd_addr = '0;
         S_RD_LAST:  rd_addr = last_ff;
         default:    rd_addr = mid_in;
      endcase
   end

   // table memory: one write port from the request, one registered read port
   always_ff @(posedge clock) begin
      if (req_xfer && (req_action == ACTION_WRITE)
          && ({1'b0, req_entry_index} < (ADDR_W + 1)'(TABLE_DEPTH))) begin
         mem[req_entry_index] <= req_entry_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= ENTRIES_RESET;
         base_ff    <= BASE_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_TABLE_ENTRIES) begin
            entries_ff <= csr_data[CNT_W-1:0];
         end else if (csr_index == CSR_BASE_TEMPERATURE) begin
            base_ff <= csr_data[BASE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // S_DONE reloads the output register itself when it is drained
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer && (req_action == ACTION_CONVERT)) begin
                  res_ff  <= req_resistance;
                  last_ff <= ADDR_W'(n_eff - CNT_W'(1));
                  if (entries_ff < CNT_W'(2)) begin
                     in_range_ff <= 1'b0;
                     state_ff    <= S_DONE;
                  end else begin
                     state_ff <= S_RD_FIRST;
                  end
               end
            end
            S_RD_FIRST: begin
               state_ff <= S_RD_LAST;
            end
            S_RD_LAST: begin
               lo_val_ff <= rd_data_ff;
               state_ff  <= S_CHK_RANGE;
            end
            S_CHK_RANGE: begin
               hi_val_ff <= rd_data_ff;
               lo_ff     <= '0;
               hi_ff     <= last_ff;
               if ((lo_val_ff >= res_ff) && (res_ff > rd_data_ff)) begin
                  in_range_ff <= 1'b1;
                  state_ff    <= S_SRCH_RD;
               end else begin
                  in_range_ff <= 1'b0;
                  state_ff    <= S_DONE;
               end
            end
            S_SRCH_RD: begin
               mid_ff <= mid_in;
               if (span > ADDR_W'(1)) begin
                  state_ff <= S_SRCH_CMP;
               end else begin
                  state_ff <= S_DIV_SETUP;
               end
            end
            S_SRCH_CMP: begin
               if (rd_data_ff >= res_ff) begin
                  lo_ff     <= mid_ff;
                  lo_val_ff <= rd_data_ff;
               end else begin
                  hi_ff     <= mid_ff;
                  hi_val_ff <= rd_data_ff;
               end
               state_ff <= S_SRCH_RD;
            end
            S_DIV_SETUP: begin
               // remainder starts below the divisor, so the quotient fits the fraction
               rem_ff     <= lo_val_ff - res_ff;
               den_ff     <= lo_val_ff - hi_val_ff;
               quo_ff     <= '0;
               div_cnt_ff <= DIV_CNT_W'(TEMP_FRAC_BITS);
               state_ff   <= S_DIV;
            end
            S_DIV: begin
               rem_ff     <= rem_in;
               quo_ff     <= {quo_ff[TEMP_FRAC_BITS-2:0], quo_bit};
               div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
               if (div_cnt_ff == DIV_CNT_W'(1)) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_slot_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_in_range_ff <= in_range_ff;
                  if (in_range_ff) begin
                     rsp_temperature_ff    <= temp_sat;
                     rsp_table_position_ff <= POS_W'(lo_ff);
                  end else begin
                     rsp_temperature_ff    <= '0;
                     rsp_table_position_ff <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_temperature    = rsp_temperature_ff;
   assign rsp_in_range       = rsp_in_range_ff;
   assign rsp_table_position = rsp_table_position_ff;

endmodule

`default_nettype wire

// ----- src/ntc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "ntc_table_interpolate_temperature_assert.svh"

module ntc_checker import ntc_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     req_action,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic signed [TEMP_W-1:0] rsp_temperature,
   input wire logic                     rsp_in_range,
   input wire logic [POS_W-1:0]         rsp_table_position
);

   logic req_xfer;
   assign req_xfer = req_valid && !req_stall;

   `NTC_ASSERT_NOW(a_oor_zero, clock, reset, rsp_valid && !rsp_in_range, (rsp_temperature == '0) && (rsp_table_position == '0), "out-of-range result must be zero")
   `NTC_ASSERT_NEXT(a_convert_busy, clock, reset, req_xfer && (req_action == ACTION_CONVERT), req_stall, "convert transfer must stall the request side")
   `NTC_ASSERT_NEXT(a_write_free, clock, reset, req_xfer && (req_action == ACTION_WRITE), !req_stall, "table write must not stall the request side")
   `NTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_temperature) && $stable(rsp_in_range) && $stable(rsp_table_position), "stalled result must hold")
   `NTC_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "no result right after reset")

endmodule

bind ntc_table_interpolate_temperature ntc_checker u_ntc_checker (.*);

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import ntc_pkg::*;

   localparam int unsigned VAL_MAX = 2 ** VAL_W - 1;
   localparam int SETTLE_CYCLES = 40;     // settle time after the queues drain
   localparam int STUCK_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 600;
   localparam int HOLD_PHASE    = 4;
   localparam int CALM_PHASE    = 8;
   localparam int PHASE_ITEMS   = 75;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = CSR_IDX_W'(3);

   typedef struct packed {
      logic              action;
      logic [ADDR_W-1:0] entry_index;
      logic [VAL_W-1:0]  entry_value;
      logic [VAL_W-1:0]  resistance;
   } sensor_item_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic                     in_range;
      logic [POS_W-1:0]         table_position;
   } reading_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_action = 1'b0;
   logic [ADDR_W-1:0]        req_entry_index = '0;
   logic [VAL_W-1:0]         req_entry_value = '0;
   logic [VAL_W-1:0]         req_resistance = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [TEMP_W-1:0] rsp_temperature;
   logic                     rsp_in_range;
   logic [POS_W-1:0]         rsp_table_position;

   // shadow of the block's state: the table follows each accepted write transfer, the registers each register write
   logic [VAL_W-1:0]         shadow_table [TABLE_DEPTH];
   logic [CNT_W-1:0]         shadow_entries = ENTRIES_RESET;
   logic signed [BASE_W-1:0] shadow_base = BASE_RESET;

   // table contents as the queued writes will leave it
   int unsigned              planned_table [TABLE_DEPTH];

   sensor_item_type pending_requests [$];
   reading_type     expected_readings [$];

   int mismatches = 0;
   int phase_num = 0;
   int stuck_cycles = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   ntc_table_interpolate_temperature u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_entry_index    (req_entry_index),
      .req_entry_value    (req_entry_value),
      .req_resistance     (req_resistance),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_temperature    (rsp_temperature),
      .rsp_in_range       (rsp_in_range),
      .rsp_table_position (rsp_table_position)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit idle_now();
      return (phase_num != CALM_PHASE) && ($urandom_range(0, 99) < 25);
   endfunction

   function automatic int unsigned entries_in_use();
      return (shadow_entries > TABLE_DEPTH) ? TABLE_DEPTH : shadow_entries;
   endfunction

   function automatic reading_type convert_resistance(input logic [VAL_W-1:0] r);
      reading_type       res;
      int unsigned       n, lo, hi, mid;
      longint unsigned   num, den, frac;
      longint            t;
      res = '0;
      n = entries_in_use();
      if (n < 2) return res;
      if (!(shadow_table[0] >= r && r > shadow_table[n-1])) return res;
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (shadow_table[mid] >= r) lo = mid;
         else hi = mid;
      end
      num  = shadow_table[lo] - r;
      den  = shadow_table[lo] - shadow_table[lo+1];
      frac = (num << TEMP_FRAC_BITS) / den;
      t = (longint'(shadow_base) + longint'(lo)) * (longint'(1) << TEMP_FRAC_BITS)
          + longint'(frac);
      if (t > TEMP_MAX) t = TEMP_MAX;
      if (t < TEMP_MIN) t = TEMP_MIN;
      res.temperature    = t[TEMP_W-1:0];
      res.in_range       = 1'b1;
      res.table_position = lo[POS_W-1:0];
      return res;
   endfunction

   // ---------------- stimulus builders ----------------

   function automatic void push_write(input int unsigned idx, input int unsigned val);
      sensor_item_type item;
      item.action      = ACTION_WRITE;
      item.entry_index = ADDR_W'(idx);
      item.entry_value = VAL_W'(val);
      item.resistance  = VAL_W'($urandom);
      planned_table[idx] = val & VAL_MAX;
      pending_requests.push_back(item);
   endfunction

   function automatic void push_convert(input logic [VAL_W-1:0] r);
      sensor_item_type item;
      item.action      = ACTION_CONVERT;
      item.entry_index = ADDR_W'($urandom);
      item.entry_value = VAL_W'($urandom);
      item.resistance  = r;
      pending_requests.push_back(item);
   endfunction

   // descending table with random steps, or random values when noise is set
   function automatic void load_table(input int unsigned count, input int unsigned step_max,
                                      input bit noise);
      int unsigned s_max, val;
      s_max = VAL_MAX / count;
      if (step_max < s_max) s_max = step_max;
      val = $urandom_range((count - 1) * s_max, VAL_MAX);
      for (int unsigned k = 0; k < count; k++) begin
         if (noise) val = $urandom_range(0, VAL_MAX);
         else if (k != 0)
            val = val - (($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, s_max));
         push_write(k, val);
      end
   endfunction

   // rewrite one entry, normally keeping the table falling
   function automatic void refresh_entry(input int unsigned idx);
      int unsigned val;
      if (idx > 0 && idx < TABLE_DEPTH - 1 &&
          planned_table[idx-1] > planned_table[idx+1] + 1 && $urandom_range(0, 19) != 0)
         val = $urandom_range(planned_table[idx+1] + 1, planned_table[idx-1] - 1);
      else if ($urandom_range(0, 3) == 0)
         val = $urandom_range(0, VAL_MAX);
      else
         val = planned_table[idx];
      push_write(idx, val);
   endfunction

   function automatic logic [VAL_W-1:0] pick_resistance();
      int unsigned n, roll, i, lowv, hiv;
      n = entries_in_use();
      roll = $urandom_range(0, 99);
      if (n < 2 || roll < 15) return VAL_W'($urandom);
      if (roll < 25) begin
         case ($urandom_range(0, 3))
            0: return VAL_W'(planned_table[0]);
            1: return VAL_W'(planned_table[0] + 1);
            2: return VAL_W'(planned_table[n-1]);
            default: return VAL_W'(planned_table[n-1] + 1);
         endcase
      end
      i = $urandom_range(0, n - 2);
      hiv = planned_table[i];
      lowv = planned_table[i+1];
      if (hiv <= lowv) return VAL_W'(hiv);
      case ($urandom_range(0, 9))
         0: return VAL_W'(hiv);
         1: return VAL_W'(lowv + 1);
         default: return VAL_W'($urandom_range(lowv + 1, hiv));
      endcase
   endfunction

   function automatic void push_random_item();
      if ($urandom_range(0, 99) < 10) refresh_entry($urandom_range(0, TABLE_DEPTH - 1));
      else push_convert(pick_resistance());
   endfunction

   // ---------------- sequencing ----------------

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_readings.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_TABLE_ENTRIES) shadow_entries = data;
      else if (idx == CSR_BASE_TEMPERATURE) shadow_base = data[BASE_W-1:0];
   endtask

   task automatic run_phase(input int unsigned entries, input logic [BASE_W-1:0] base,
                            input int unsigned reload, input int unsigned step_max,
                            input bit noise);
      wait_drained();
      write_register(CSR_TABLE_ENTRIES, CSR_DATA_W'(entries));
      write_register(CSR_BASE_TEMPERATURE, {1'($urandom), base});
      write_register($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3, CSR_DATA_W'($urandom));
      @(negedge clock);
      phase_num++;
      if (reload != 0) load_table(reload, step_max, noise);
      repeat (PHASE_ITEMS) push_random_item();
   endtask

   initial begin
      int unsigned rand_n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // full load, then edges of the table at the reset entry count
      load_table(TABLE_DEPTH, VAL_MAX, 1'b0);
      push_write(0, 24'hFFFFF8);
      push_write(TABLE_DEPTH - 1, 0);
      push_convert(24'hFFFFFF);
      push_convert(24'h000000);
      push_convert(VAL_W'(planned_table[0]));
      push_convert(VAL_W'(planned_table[0] + 1));
      push_convert(VAL_W'(planned_table[ENTRIES_RESET-1]));  // last entry in use is excluded
      push_convert(VAL_W'(planned_table[ENTRIES_RESET-1] + 1));
      push_convert(VAL_W'(planned_table[ENTRIES_RESET-2]));
      push_convert(VAL_W'(planned_table[1] + 1));
      push_convert(VAL_W'(planned_table[70]));
      push_convert(VAL_W'(planned_table[ENTRIES_RESET]));    // beyond the entries in use
      refresh_entry(70);
      push_convert(VAL_W'(planned_table[70]));
      push_convert(VAL_W'(planned_table[71] + 1));
      repeat (PHASE_ITEMS) push_random_item();

      run_phase(2, BASE_W'(-128), 2, VAL_MAX, 1'b0);
      run_phase(3, BASE_W'(127), 3, 3, 1'b0);
      run_phase(TABLE_DEPTH, BASE_W'(0), TABLE_DEPTH, 3, 1'b0);
      run_phase(TABLE_DEPTH + 1, BASE_W'(-55), 0, 0, 1'b0);
      run_phase(0, BASE_W'(5), 0, 0, 1'b0);
      run_phase(1, BASE_W'(-7), 0, 0, 1'b0);
      run_phase(100, BASE_W'(60), 100, VAL_MAX, 1'b1);
      run_phase(2 ** CNT_W - 1, BASE_W'(-1), TABLE_DEPTH, VAL_MAX, 1'b0);
      rand_n = $urandom_range(2, TABLE_DEPTH);
      run_phase(rand_n, BASE_W'($urandom), 0, 0, 1'b0);
      rand_n = $urandom_range(2, 64);
      run_phase(rand_n, BASE_W'($urandom), rand_n, 4096, 1'b0);
      run_phase(ENTRIES_RESET, BASE_RESET, 0, 0, 1'b0);

      wait_drained();
      if (mismatches == 0)
         $display("ntc_table_interpolate_temperature: match");
      else
         $display("ntc_table_interpolate_temperature: mismatch");
      $finish;
   end

   // ---------------- request driver ----------------

   always @(posedge clock) begin
      sensor_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_action == ACTION_WRITE)
               shadow_table[req_entry_index] = req_entry_value;
            else
               expected_readings.push_back(convert_resistance(req_resistance));
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 && !idle_now()) begin
               item = pending_requests.pop_front();
               req_valid       <= 1'b1;
               req_action      <= item.action;
               req_entry_index <= item.entry_index;
               req_entry_value <= item.entry_value;
               req_resistance  <= item.resistance;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- result monitor ----------------

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               $error("unexpected transfer: temperature %0d", rsp_temperature);
               mismatches++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_temperature !== want.temperature) begin
                  $error("temperature: expected %0d, got %0d", want.temperature,
                         rsp_temperature);
                  mismatches++;
               end
               if (rsp_in_range !== want.in_range) begin
                  $error("in_range: expected %0d, got %0d", want.in_range, rsp_in_range);
                  mismatches++;
               end
               if (rsp_table_position !== want.table_position) begin
                  $error("table_position: expected %0d, got %0d", want.table_position,
                         rsp_table_position);
                  mismatches++;
               end
            end
         end
         // one long back-pressure stretch so the block fills and stalls its input
         if (phase_num == HOLD_PHASE && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= idle_now();
         end
      end
   end

   // ---------------- watchdog ----------------

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("ntc_table_interpolate_temperature: mismatch");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

endmodule
